// ===== rtl/bcic_pkg.sv =====
// bcic_pkg: shared constants and types of the block column index collector
// used by bcic_div, bcic_cell and block_column_index_collector; no dependencies
package bcic_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int COLUMN_BITS = 20;
    localparam int CFG_W       = 7;
    localparam int KEPT_W      = $clog2(MAX_SLOTS + 1);
    localparam int BCOL_W      = COLUMN_BITS + 1;
    localparam int CNT_W       = $clog2(COLUMN_BITS);

    // result tdata: block_col, distinct_count, overflow, padded to bytes
    localparam int M_FIELDS_W  = BCOL_W + KEPT_W + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    // input tdata: col_index, padded to bytes
    localparam int S_TDATA_W   = ((COLUMN_BITS + 7) / 8) * 8;

    // register indexes of the configuration channel
    localparam logic REG_BLK_DIM    = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] BLK_DIM_RST    = CFG_W'(16);
    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(64);

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic cmp;   // compare stored value against the key
        logic ins;   // insert key, shifting larger values right
        logic emit;  // shift the list one place towards the head
    } cell_ctrl_t;

endpackage

// ===== rtl/bcic_div.sv =====
// bcic_div: bit-serial restoring divider, one quotient bit per cycle
// depends on bcic_pkg for the column width
module bcic_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [bcic_pkg::COLUMN_BITS-1:0]    dividend,
    input  logic [bcic_pkg::CFG_W-1:0]          divisor,
    output logic                                done,
    output logic [bcic_pkg::COLUMN_BITS-1:0]    quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [bcic_pkg::CNT_W-1:0]         cnt_reg;
    logic [bcic_pkg::CFG_W-1:0]         rem_reg;
    logic [bcic_pkg::CFG_W-1:0]         div_reg;
    logic [bcic_pkg::COLUMN_BITS-1:0]   quo_reg;
    logic [bcic_pkg::CFG_W:0]           shifted;
    logic [bcic_pkg::CFG_W+1:0]         trial;
    logic                               borrow;

    assign shifted = {rem_reg, quo_reg[bcic_pkg::COLUMN_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign borrow  = trial[bcic_pkg::CFG_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == bcic_pkg::CNT_W'(bcic_pkg::COLUMN_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= dividend;
            // zero divisor acts as one
            div_reg <= (divisor == '0) ? bcic_pkg::CFG_W'(1) : divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + bcic_pkg::CNT_W'(1);
            rem_reg <= borrow ? shifted[bcic_pkg::CFG_W-1:0] : trial[bcic_pkg::CFG_W-1:0];
            quo_reg <= {quo_reg[bcic_pkg::COLUMN_BITS-2:0], ~borrow};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/bcic_cell.sv =====
// bcic_cell: one slot of the sorted block-column list
// depends on bcic_pkg; talks to its left and right neighbours in the chain
module bcic_cell (
    input  logic                                aclk,
    input  bcic_pkg::cell_ctrl_t                ctrl,
    input  logic [bcic_pkg::COLUMN_BITS-1:0]    key,
    input  logic                                row_valid,
    input  logic                                left_ge,
    input  logic [bcic_pkg::COLUMN_BITS-1:0]    left_val,
    input  logic [bcic_pkg::COLUMN_BITS-1:0]    right_val,
    output logic [bcic_pkg::COLUMN_BITS-1:0]    val,
    output logic                                ge,
    output logic                                eq
);

    logic [bcic_pkg::COLUMN_BITS-1:0] val_reg;
    logic                             ge_reg;
    logic                             eq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp) begin
            // ge: slot is empty or holds a value not below the key
            ge_reg <= !(row_valid && (val_reg < key));
            eq_reg <= row_valid && (val_reg == key);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            val_reg <= right_val;
        end else if (ctrl.ins && ge_reg) begin
            // first shifting slot takes the key, the rest take the left value
            val_reg <= left_ge ? left_val : key;
        end
    end

    assign val = val_reg;
    assign ge  = ge_reg;
    assign eq  = eq_reg;

endmodule

// ===== rtl/block_column_index_collector.sv =====
// block_column_index_collector: top level, gathers sorted distinct block columns
// depends on bcic_pkg, bcic_div and bcic_cell
//
// Collects the column indices of one block row, divides each by the configured
// block dimension and keeps the distinct block-column numbers in ascending order
// in a chain of MAX_SLOTS cells. An input transaction with tuser (has_entry) set
// carries a column index; tlast (end_of_block_row) closes the row, with or without
// an entry, and the block then sends one result transaction per slot: the sorted
// numbers first, then -1 for each empty slot, tlast on the final slot. Every
// result carries the distinct count and an overflow flag; when more distinct
// numbers arrive than slot_count allows, the smallest are kept and overflow is
// set. An item with an entry occupies the block from its accepting edge to the
// next one: the bit-serial divider that produces one quotient bit per cycle,
// the registered done flag through which the quotient is seen, a compare step
// and an insert step in the cell chain, and the idle state in which the next
// item is taken. A bare marker goes straight to emission. Emission then shifts
// the chain one slot per cycle while the result side does not stall. A new item
// is accepted as soon as the final slot sits in the output register.
// Configuration writes are always accepted; they are expected only while no
// item is in progress.
module block_column_index_collector (
    input  logic                                aclk,
    input  logic                                aresetn,

    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bcic_pkg::S_TDATA_W-1:0]      s_tdata,   // [19:0] col_index, rest zero
    input  logic                                s_tuser,   // [0] has_entry
    input  logic                                s_tlast,   // end_of_block_row

    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bcic_pkg::M_TDATA_W-1:0]      m_tdata,   // [20:0] block_col,
                                                           // [27:21] distinct_count,
                                                           // [28] overflow, rest zero
    output logic                                m_tlast,   // last_slot

    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [bcic_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int N  = bcic_pkg::MAX_SLOTS;
    localparam int CW = bcic_pkg::COLUMN_BITS;
    localparam int KW = bcic_pkg::KEPT_W;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic [bcic_pkg::CFG_W-1:0]     blk_dim_reg;
    logic [bcic_pkg::CFG_W-1:0]     slot_count_reg;
    logic [KW-1:0]                  kept_reg, kept_next;
    logic                           ovf_seen_reg, ovf_seen_next;
    logic [KW-1:0]                  slot_reg, slot_next;
    logic                           eob_reg;
    logic                           m_tvalid_reg, m_tvalid_next;

    // payload
    logic [CW-1:0]                  col_reg;
    logic [bcic_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tlast_reg;

    logic                           s_accept;
    logic                           div_start;
    logic                           div_done;
    logic [CW-1:0]                  key;
    bcic_pkg::cell_ctrl_t           ctrl;
    logic                           dup;
    logic                           out_free;
    logic                           emit_load;

    logic [KW-1:0]                  cap;
    logic [KW-1:0]                  shown;
    logic                           ovf_now;
    logic                           last_slot;
    logic [bcic_pkg::BCOL_W-1:0]    block_col;

    logic [CW-1:0]                  cell_val [N];
    logic [N-1:0]                   cell_ge;
    logic [N-1:0]                   cell_eq;
    logic [N-1:0]                   cell_row_valid;

    // configuration channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_dim_reg    <= bcic_pkg::BLK_DIM_RST;
            slot_count_reg <= bcic_pkg::SLOT_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bcic_pkg::REG_BLK_DIM:    blk_dim_reg    <= cfg_data;
                bcic_pkg::REG_SLOT_COUNT: slot_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective slot count: zero acts as one, clamped to the chain length
    always_comb begin
        priority if (slot_count_reg == '0) begin
            cap = KW'(1);
        end else if (slot_count_reg > bcic_pkg::CFG_W'(N)) begin
            cap = KW'(N);
        end else begin
            cap = KW'(slot_count_reg);
        end
    end

    assign shown   = (kept_reg < cap) ? kept_reg : cap;
    assign ovf_now = ovf_seen_reg || (kept_reg > cap);

    // input side
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign div_start = s_accept && s_tuser;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_reg <= s_tdata[CW-1:0];
            eob_reg <= s_tlast;
        end
    end

    bcic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_tdata[CW-1:0]),
        .divisor  (blk_dim_reg),
        .done     (div_done),
        .quotient (key)
    );

    // cell chain: cell 0 holds the smallest number and feeds the output
    assign dup = |cell_eq;

    always_comb begin
        ctrl.cmp  = (state_reg == ST_CMP);
        ctrl.ins  = (state_reg == ST_INS) && !dup;
        ctrl.emit = emit_load;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic          l_ge;
        logic [CW-1:0] l_val;
        logic [CW-1:0] r_val;

        assign cell_row_valid[i] = (KW'(i) < kept_reg);

        if (i == 0) begin : g_head
            assign l_ge  = 1'b0;
            assign l_val = '0;
        end else begin : g_body
            assign l_ge  = cell_ge[i-1];
            assign l_val = cell_val[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign r_val = '0;
        end else begin : g_inner
            assign r_val = cell_val[i+1];
        end

        bcic_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .key       (key),
            .row_valid (cell_row_valid[i]),
            .left_ge   (l_ge),
            .left_val  (l_val),
            .right_val (r_val),
            .val       (cell_val[i]),
            .ge        (cell_ge[i]),
            .eq        (cell_eq[i])
        );
    end

    // emission: one slot per cycle whenever the output register is free
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;
    assign last_slot = (slot_reg == cap - KW'(1));
    assign block_col = (slot_reg < shown) ? {1'b0, cell_val[0]} : '1;

    always_comb begin
        state_next    = state_reg;
        kept_next     = kept_reg;
        ovf_seen_next = ovf_seen_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_tuser) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_EMIT;
                        slot_next  = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_INS;
            end
            ST_INS: begin
                if (!dup) begin
                    if (kept_reg < cap) begin
                        kept_next = kept_reg + KW'(1);
                    end else begin
                        // full: the largest kept number drops out, if any
                        ovf_seen_next = 1'b1;
                    end
                end
                state_next = eob_reg ? ST_EMIT : ST_IDLE;
                slot_next  = '0;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_tvalid_next = 1'b1;
                    slot_next     = slot_reg + KW'(1);
                    if (last_slot) begin
                        state_next    = ST_IDLE;
                        kept_next     = '0;
                        ovf_seen_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kept_reg     <= '0;
            ovf_seen_reg <= 1'b0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kept_reg     <= kept_next;
            ovf_seen_reg <= ovf_seen_next;
            slot_reg     <= slot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register holds one result transaction
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_tdata_reg <= bcic_pkg::M_TDATA_W'({ovf_now, shown, block_col});
            m_tlast_reg <= last_slot;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== test/block_column_index_collector_test.sv =====
// block_column_index_collector_test: self-checking bench for the block column index collector
// drives column-index streams and register writes, predicts every emitted slot;
// depends on bcic_pkg and block_column_index_collector
module block_column_index_collector_test;

    localparam int COLUMN_BITS = bcic_pkg::COLUMN_BITS;
    localparam int MAX_SLOTS   = bcic_pkg::MAX_SLOTS;
    localparam int CFG_W       = bcic_pkg::CFG_W;
    localparam int KEPT_W      = bcic_pkg::KEPT_W;
    localparam int BCOL_W      = bcic_pkg::BCOL_W;
    localparam int S_TDATA_W   = bcic_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = bcic_pkg::M_TDATA_W;

    // a row with an entry may still be dividing after the last slot has left
    localparam int SETTLE_CYCLES = COLUMN_BITS + 3 + 16;

    // one emitted slot as seen on the result stream
    typedef struct {
        logic signed [BCOL_W-1:0] block_col;
        logic [KEPT_W-1:0]        distinct_count;
        logic                     overflow;
        logic                     last_slot;
    } slot_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [19:0] col_index, rest zero
    logic                   s_tuser   = 1'b0; // [0] has_entry
    logic                   s_tlast   = 1'b0; // end_of_block_row
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [20:0] block_col, [27:21] count, [28] overflow
    logic                   m_tlast;          // last_slot
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = bcic_pkg::REG_BLK_DIM;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // predictor state: sorted distinct block numbers of the open row
    logic [COLUMN_BITS-1:0] block_list [MAX_SLOTS];
    int unsigned            kept_blocks    = 0;
    bit                     overflow_seen  = 1'b0;
    logic [CFG_W-1:0]       blk_dim_reg    = bcic_pkg::BLK_DIM_RST;
    logic [CFG_W-1:0]       slot_count_reg = bcic_pkg::SLOT_COUNT_RST;
    slot_t                  expected_slots [$];

    int unsigned            error_count   = 0;
    int unsigned            items_sent    = 0;
    int unsigned            rows_closed   = 0;
    int unsigned            slots_checked = 0;
    int unsigned            stall_left    = 0;
    int unsigned            row_base      = 0;
    bit                     steady        = 1'b0;   // no idling on either side

    block_column_index_collector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // slot_count clamped to 1..MAX_SLOTS
    function automatic int unsigned slots_in_use();
        if (slot_count_reg == 0) return 1;
        if (slot_count_reg > MAX_SLOTS) return MAX_SLOTS;
        return slot_count_reg;
    endfunction

    // sorted insert; duplicates vanish, a full list keeps its smallest numbers
    function automatic void add_block_number(input logic [COLUMN_BITS-1:0] num,
                                             input int unsigned cap);
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        n   = (kept_blocks > MAX_SLOTS) ? MAX_SLOTS : kept_blocks;
        pos = 0;
        while (pos < n && block_list[pos] < num) pos++;
        if (pos < n && block_list[pos] == num) return;
        if (n < cap) begin
            for (i = n; i > pos; i--) block_list[i] = block_list[i - 1];
            block_list[pos] = num;
            kept_blocks = n + 1;
            return;
        end
        // list full: flag it, and a smaller number pushes out the largest
        overflow_seen = 1'b1;
        if (pos < n) begin
            for (i = n - 1; i > pos; i--) block_list[i] = block_list[i - 1];
            block_list[pos] = num;
        end
    endfunction

    // one slot per ELL column: sorted numbers, then -1 padding
    function automatic void close_block_row();
        int unsigned cap;
        int unsigned shown;
        int unsigned k;
        slot_t       s;
        cap   = slots_in_use();
        shown = (kept_blocks < cap) ? kept_blocks : cap;
        for (k = 0; k < cap; k++) begin
            if (k < shown) s.block_col = $signed({1'b0, block_list[k]});
            else           s.block_col = -1;
            s.distinct_count = KEPT_W'(shown);
            s.overflow       = overflow_seen || (kept_blocks > cap);
            s.last_slot      = (k + 1 == cap);
            expected_slots.push_back(s);
        end
        kept_blocks   = 0;
        overflow_seen = 1'b0;
        rows_closed++;
    endfunction

    // entry goes in first, then the marker closes the row
    function automatic void collect_column(input logic [COLUMN_BITS-1:0] col,
                                           input bit has_entry, input bit end_of_row);
        int unsigned divisor;
        divisor = (blk_dim_reg == 0) ? 1 : blk_dim_reg;
        if (has_entry) add_block_number(COLUMN_BITS'(col / divisor), slots_in_use());
        if (end_of_row) close_block_row();
    endfunction

    // ---------------------------------------------------------------- idling

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // result side back-pressure, one assignment per falling edge
    always @(negedge aclk) begin
        if (steady || stall_left == 0) begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20) stall_left = idle_len();
        end else begin
            m_tready <= 1'b0;
            stall_left--;
        end
    end

    // ---------------------------------------------------------------- checking

    // every result transaction against the oldest predicted slot
    always @(posedge aclk) begin
        slot_t                    want;
        logic signed [BCOL_W-1:0] got_col;
        logic [KEPT_W-1:0]        got_count;
        if (aresetn && m_tvalid && m_tready) begin
            got_col   = m_tdata[BCOL_W-1:0];
            got_count = m_tdata[BCOL_W +: KEPT_W];
            if (expected_slots.size() == 0) begin
                $error("unexpected result transaction: block_col %0d", got_col);
                error_count++;
            end else begin
                want = expected_slots.pop_front();
                slots_checked++;
                if (got_col !== want.block_col) begin
                    $error("block_col: expected %0d, got %0d", want.block_col, got_col);
                    error_count++;
                end
                if (got_count !== want.distinct_count) begin
                    $error("distinct_count: expected %0d, got %0d",
                           want.distinct_count, got_count);
                    error_count++;
                end
                if (m_tdata[BCOL_W + KEPT_W] !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, m_tdata[BCOL_W + KEPT_W]);
                    error_count++;
                end
                if (m_tlast !== want.last_slot) begin
                    $error("last_slot: expected %0b, got %0b", want.last_slot, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // one input transaction; called and returning at a falling edge
    task automatic send_item(input logic [COLUMN_BITS-1:0] col, input bit has_entry,
                             input bit end_of_row);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(col);
        s_tuser  <= has_entry;
        s_tlast  <= end_of_row;
        do @(posedge aclk); while (!s_tready);
        collect_column(col, has_entry, end_of_row);
        // a transaction with neither entry nor marker does nothing
        if (has_entry || end_of_row) items_sent++;
        @(negedge aclk);
    endtask

    // sender stops until every slot is back and the divider has surely finished
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_slots.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == bcic_pkg::REG_BLK_DIM) blk_dim_reg    = value;
        else                              slot_count_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] bsize, input logic [CFG_W-1:0] slots);
        write_reg(bcic_pkg::REG_BLK_DIM, bsize);
        write_reg(bcic_pkg::REG_SLOT_COUNT, slots);
    endtask

    // column near the row's base, or anywhere now and then
    function automatic logic [COLUMN_BITS-1:0] pick_column(input int unsigned spread);
        int unsigned divisor;
        divisor = (blk_dim_reg == 0) ? 1 : blk_dim_reg;
        if ($urandom_range(0, 3) == 0) return COLUMN_BITS'($urandom);
        return COLUMN_BITS'(row_base + $urandom_range(0, divisor * spread - 1));
    endfunction

    // ---------------------------------------------------------------- tests

    // reset settings: extreme columns, a duplicate, entry with marker, empty row
    task automatic test_reset_settings();
        send_item(COLUMN_BITS'(0), 1'b1, 1'b0);
        send_item('1, 1'b1, 1'b0);
        send_item(COLUMN_BITS'(15), 1'b1, 1'b0);   // same block as column 0
        send_item(COLUMN_BITS'(16), 1'b1, 1'b1);
        send_item(COLUMN_BITS'(0), 1'b0, 1'b1);    // nothing collected: all -1
    endtask

    // two slots: a larger number only flags, a smaller one displaces the largest
    task automatic test_overflow_keeps_smallest();
        quiesce();
        set_geometry(CFG_W'(1), CFG_W'(2));
        send_item(COLUMN_BITS'(5), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(3), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(9), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(1), 1'b1, 1'b1);
        send_item(COLUMN_BITS'(3), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(3), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(0), 1'b0, 1'b1);
    endtask

    // zero and all-ones register values clamp
    task automatic test_clamped_settings();
        quiesce();
        set_geometry(CFG_W'(0), CFG_W'(0));
        send_item(COLUMN_BITS'(7), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(7), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(8), 1'b1, 1'b1);
        quiesce();
        set_geometry('1, '1);
        send_item('1, 1'b1, 1'b0);
        send_item(COLUMN_BITS'(381), 1'b1, 1'b0);
        send_item(COLUMN_BITS'(0), 1'b0, 1'b1);
    endtask

    // six blocks held, then slot_count drops to three before the marker
    task automatic test_slot_count_lowered_mid_row();
        int unsigned i;
        quiesce();
        set_geometry(CFG_W'(4), CFG_W'(8));
        for (i = 0; i < 6; i++) send_item(COLUMN_BITS'(40 - 6 * i), 1'b1, 1'b0);
        quiesce();
        write_reg(bcic_pkg::REG_SLOT_COUNT, CFG_W'(3));
        send_item(COLUMN_BITS'(0), 1'b0, 1'b1);
    endtask

    // mostly well-formed rows with random columns, some stray transactions
    task automatic test_random_rows();
        int unsigned      phase;
        int unsigned      budget;
        int unsigned      cap;
        int unsigned      row_len;
        int unsigned      n;
        logic [CFG_W-1:0] bsize;
        logic [CFG_W-1:0] slots;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    bsize = CFG_W'(1);
                    slots = CFG_W'(64);
                end
                1: begin
                    bsize = CFG_W'(64);
                    slots = CFG_W'(1);
                end
                2: begin
                    bsize = CFG_W'(0);
                    slots = '1;
                end
                3: begin
                    bsize = '1;
                    slots = CFG_W'(0);
                end
                default: begin
                    bsize = CFG_W'($urandom_range(1, 64));
                    slots = CFG_W'($urandom_range(1, 16));
                end
            endcase
            quiesce();
            set_geometry(bsize, slots);
            steady = (phase % 3 == 2);
            cap    = slots_in_use();
            budget = items_sent + 26;
            while (items_sent < budget) begin
                // long rows push past the slot limit when that is cheap to do
                if (cap <= 16 && $urandom_range(0, 3) == 0)
                    row_len = $urandom_range(cap, cap + 6);
                else
                    row_len = $urandom_range(0, (cap + 2 < 10) ? cap + 2 : 10);
                row_base = $urandom_range(0, (1 << COLUMN_BITS) - 10000);
                for (n = 0; n < row_len; n++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(COLUMN_BITS'($urandom), 1'b0, 1'b0);
                    send_item(pick_column(cap + 3), 1'b1, 1'b0);
                end
                // close with a bare marker or with one carried by an entry
                if ($urandom_range(0, 1) != 0) send_item(pick_column(cap + 3), 1'b1, 1'b1);
                else                           send_item(COLUMN_BITS'($urandom), 1'b0, 1'b1);
                if ($urandom_range(0, 5) == 0) quiesce();
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_settings();
        test_overflow_keeps_smallest();
        test_clamped_settings();
        test_slot_count_lowered_mid_row();
        test_random_rows();

        quiesce();
        $display("covered %0d entry or marker transactions, %0d block rows, %0d slots checked",
                 items_sent, rows_closed, slots_checked);
        if (error_count == 0) begin
            $display("block_column_index_collector_test: done, clean");
        end else begin
            $display("block_column_index_collector_test: done, errors");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #40000000;
        $display("block_column_index_collector_test: done, errors");
        $finish;
    end

endmodule
